[src/rar_pkg.sv]
// ----------------------------------------------------------------------------
// rar_pkg
// shared types and constants of the rational alu with gcd reduction
// ----------------------------------------------------------------------------
`default_nettype none

package rar_pkg;

	localparam int OPERAND_WIDTH_DEF = 15;
	localparam int RES_NUM_W         = 31;
	localparam int RES_DEN_W         = 30;
	localparam int OUT_TDATA_W       = 64;

	// operation codes carried on the request tuser
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// which product the shared multiplier forms
	typedef enum logic [1:0] {
		MUL_T0 = 2'd0,
		MUL_T1 = 2'd1,
		MUL_D  = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     comb;
		logic     gcd_step;
		logic     div_init;
		logic     div_step;
		logic     push;
	} cmd_t;

	typedef struct packed {
		logic err;
		logic gcd_done;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

[src/rar_ctrl.sv]
// ----------------------------------------------------------------------------
// rar_ctrl
// sequencer: multiply steps, combine, binary gcd loop, division, result push
// ----------------------------------------------------------------------------
`default_nettype none

module rar_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire rar_pkg::stat_t st,
	output rar_pkg::cmd_t      cmd
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MUL0  = 9'b000000010,
		S_MUL1  = 9'b000000100,
		S_MUL2  = 9'b000001000,
		S_COMB  = 9'b000010000,
		S_GCD   = 9'b000100000,
		S_DINIT = 9'b001000000,
		S_DIV   = 9'b010000000,
		S_PUSH  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = rar_pkg::MUL_T0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL0;
				end
			end
			S_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rar_pkg::MUL_T0;
				state_d     = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rar_pkg::MUL_T1;
				state_d     = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rar_pkg::MUL_D;
				state_d     = S_COMB;
			end
			S_COMB: begin
				cmd.comb = 1'b1;
				state_d  = S_GCD;
			end
			S_GCD: begin
				priority if (st.err) begin
					state_d = S_PUSH;
				end else if (st.gcd_done) begin
					state_d = S_DINIT;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_load_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_MUL0))
		else $error("accepted request did not start the multiply sequence");
`endif

endmodule

`default_nettype wire

[src/rar_datapath.sv]
// ----------------------------------------------------------------------------
// rar_datapath
// shared multiplier, combine adder, binary gcd unit, two restoring dividers
// ----------------------------------------------------------------------------
`default_nettype none

module rar_datapath #(
	parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [1:0]               req_type,
	input  wire logic [OPERAND_WIDTH-1:0] a_num,
	input  wire logic [OPERAND_WIDTH-1:0] a_den,
	input  wire logic [OPERAND_WIDTH-1:0] b_num,
	input  wire logic [OPERAND_WIDTH-1:0] b_den,
	input  wire rar_pkg::cmd_t            cmd,
	output rar_pkg::stat_t                st,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [rar_pkg::RES_NUM_W-1:0] res_num,
	output logic [rar_pkg::RES_DEN_W-1:0] res_den,
	output logic                          status
);

	localparam int PW = 2 * OPERAND_WIDTH;
	localparam int NW = PW + 1;
	localparam int CW = $clog2(NW + 1);

	logic [1:0]               op_q;
	logic [OPERAND_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic                     err_q;
	logic [PW-1:0]            t0_q, t1_q, d_q;
	logic [NW-1:0]            n_q;
	logic [NW-1:0]            gx_q, gy_q, g_q;
	logic [CW-1:0]            k_q, cnt_q;
	logic [NW-1:0]            qn_q, qd_q, rn_q, rd_q;

	// shared multiplier
	logic [OPERAND_WIDTH-1:0] mul_a, mul_b;
	logic [PW-1:0]            prod;

	always_comb begin
		unique case (cmd.mul_sel)
			rar_pkg::MUL_T0: begin
				mul_a = an_q;
				mul_b = (op_q == rar_pkg::OP_MUL) ? bn_q : bd_q;
			end
			rar_pkg::MUL_T1: begin
				mul_a = ad_q;
				mul_b = bn_q;
			end
			rar_pkg::MUL_D: begin
				mul_a = ad_q;
				mul_b = (op_q == rar_pkg::OP_DIV) ? bn_q : bd_q;
			end
			default: begin
				mul_a = an_q;
				mul_b = bd_q;
			end
		endcase
	end

	assign prod = {{OPERAND_WIDTH{1'b0}}, mul_a} * {{OPERAND_WIDTH{1'b0}}, mul_b};

	// combine
	logic [NW-1:0] sum_w, diff_w, nval;
	logic          sub_bad;

	assign sum_w   = {1'b0, t0_q} + {1'b0, t1_q};
	assign diff_w  = {1'b0, t0_q} - {1'b0, t1_q};
	assign sub_bad = (t0_q <= t1_q);

	always_comb begin
		unique case (op_q)
			rar_pkg::OP_ADD: nval = sum_w;
			rar_pkg::OP_SUB: nval = diff_w;
			default:         nval = {1'b0, t0_q};
		endcase
	end

	// binary gcd step: one subtract, halving folded in
	logic [NW:0]   dxy;
	logic          borrow;
	logic [NW-1:0] dabs, half;

	assign dxy    = {1'b0, gx_q} - {1'b0, gy_q};
	assign borrow = dxy[NW];
	assign dabs   = borrow ? (~dxy[NW-1:0] + NW'(1)) : dxy[NW-1:0];
	assign half   = dabs >> 1;

	// restoring dividers, numerator and denominator side by side
	logic [NW:0] tn, td, sn, sd;
	logic        gen, ged;

	assign tn  = {rn_q, qn_q[NW-1]};
	assign td  = {rd_q, qd_q[NW-1]};
	assign sn  = tn - {1'b0, g_q};
	assign sd  = td - {1'b0, g_q};
	assign gen = !sn[NW];
	assign ged = !sd[NW];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_type;
			an_q  <= a_num;
			ad_q  <= a_den;
			bn_q  <= b_num;
			bd_q  <= b_den;
			err_q <= (a_num == '0) || (a_den == '0) || (b_num == '0) || (b_den == '0);
		end
		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				rar_pkg::MUL_T0: t0_q <= prod;
				rar_pkg::MUL_T1: t1_q <= prod;
				default:         d_q  <= prod;
			endcase
		end
		if (cmd.comb) begin
			n_q   <= nval;
			gx_q  <= nval;
			gy_q  <= {1'b0, d_q};
			k_q   <= '0;
			err_q <= err_q || ((op_q == rar_pkg::OP_SUB) && sub_bad);
		end
		if (cmd.gcd_step) begin
			priority if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				k_q  <= k_q + CW'(1);
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (!borrow) begin
				gx_q <= half;
			end else begin
				gy_q <= half;
			end
		end
		if (cmd.div_init) begin
			g_q   <= (gx_q | gy_q) << k_q;
			qn_q  <= n_q;
			qd_q  <= {1'b0, d_q};
			rn_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rn_q  <= gen ? sn[NW-1:0] : tn[NW-1:0];
			rd_q  <= ged ? sd[NW-1:0] : td[NW-1:0];
			qn_q  <= {qn_q[NW-2:0], gen};
			qd_q  <= {qd_q[NW-2:0], ged};
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.push) begin
			res_num <= err_q ? '0 : rar_pkg::RES_NUM_W'(qn_q);
			res_den <= err_q ? '0 : rar_pkg::RES_DEN_W'(qd_q);
			status  <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			priority if (cmd.push) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign st.err      = err_q;
	assign st.gcd_done = (gx_q == '0) || (gy_q == '0);
	assign st.div_last = (cnt_q == CW'(NW - 1));
	assign st.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid || out_ready))
		else $error("result pushed over an untaken result");
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step |-> ((gx_q != '0) && (gy_q != '0)))
		else $error("gcd step on a zero operand");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (g_q != '0))
		else $error("division by a zero gcd");
`endif

endmodule

`default_nettype wire

[src/rational_alu_with_reduction.sv]
// sequence: multiply steps, combine, binary gcd steps, then restoring division steps;
// error requests skip gcd and division
// one request at a time: the next request is taken once its result has been pushed
// into the output register, which holds it until taken
// arst_n clears the sequencer and the output valid; data registers are not reset
// ----------------------------------------------------------------------------
// rational_alu_with_reduction
// add, subtract, multiply or divide two fractions and reduce the result by its gcd
// ----------------------------------------------------------------------------
`default_nettype none

module rational_alu_with_reduction #(
	parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF,
	localparam int InTdataW = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// a_num, a_den, b_num, b_den from bit 0 up
	input  wire logic [InTdataW-1:0]           s_axis_tdata,
	// req_type
	input  wire logic [1:0]                    s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// res_num, res_den from bit 0 up
	output logic [rar_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// status
	output logic [0:0]                         m_axis_tuser
);

	localparam int W = OPERAND_WIDTH;

	rar_pkg::cmd_t  cmd;
	rar_pkg::stat_t st;

	logic [rar_pkg::RES_NUM_W-1:0] res_num;
	logic [rar_pkg::RES_DEN_W-1:0] res_den;
	logic                          status;

	rar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	rar_datapath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_type  (s_axis_tuser),
		.a_num     (s_axis_tdata[W-1:0]),
		.a_den     (s_axis_tdata[2*W-1:W]),
		.b_num     (s_axis_tdata[3*W-1:2*W]),
		.b_den     (s_axis_tdata[4*W-1:3*W]),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_num   (res_num),
		.res_den   (res_den),
		.status    (status)
	);

	assign m_axis_tdata = {
		{(rar_pkg::OUT_TDATA_W - rar_pkg::RES_NUM_W - rar_pkg::RES_DEN_W){1'b0}},
		res_den, res_num};
	assign m_axis_tuser = status;

endmodule

`default_nettype wire

[tb/fraction_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_checker
// watches both streams of the rational alu. it predicts the reduced fraction
// and the status for every accepted request, then compares each accepted
// result with the oldest prediction.
// ----------------------------------------------------------------------------

module fraction_checker #(
	parameter int OPW = rar_pkg::OPERAND_WIDTH_DEF,
	localparam int IN_W = ((4 * OPW + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	input  wire logic                          s_axis_tready,
	// a_num, a_den, b_num, b_den from bit 0 up
	input  wire logic [IN_W-1:0]               s_axis_tdata,
	// req_type
	input  wire logic [1:0]                    s_axis_tuser,
	input  wire logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// res_num, res_den from bit 0 up
	input  wire logic [rar_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// status
	input  wire logic [0:0]                    m_axis_tuser,
	output int                                 fail_count,
	output int                                 pending_count
);

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct {
		logic [rar_pkg::RES_NUM_W-1:0] num;
		logic [rar_pkg::RES_DEN_W-1:0] den;
		logic                          status;
	} fraction_t;

	fraction_t expected_fracs[$];

	function automatic fraction_t reduced_fraction(input logic [1:0] op,
			input logic [IN_W-1:0] data);
		logic [OPW-1:0] an, ad, bn, bd;
		longint unsigned n, d, x, y, r, cross_a, cross_b;
		fraction_t f;
		an = data[OPW-1:0];
		ad = data[2*OPW-1:OPW];
		bn = data[3*OPW-1:2*OPW];
		bd = data[4*OPW-1:3*OPW];
		f.num = '0;
		f.den = '0;
		f.status = STATUS_ERR;
		if (an == 0 || ad == 0 || bn == 0 || bd == 0) begin
			return f;
		end
		cross_a = 64'(an) * 64'(bd);
		cross_b = 64'(ad) * 64'(bn);
		case (op)
			rar_pkg::OP_ADD: begin
				n = cross_a + cross_b;
				d = 64'(ad) * 64'(bd);
			end
			rar_pkg::OP_SUB: begin
				// difference must stay strictly positive
				if (cross_a <= cross_b) begin
					return f;
				end
				n = cross_a - cross_b;
				d = 64'(ad) * 64'(bd);
			end
			rar_pkg::OP_MUL: begin
				n = 64'(an) * 64'(bn);
				d = 64'(ad) * 64'(bd);
			end
			default: begin
				n = cross_a;
				d = cross_b;
			end
		endcase
		x = (n > d) ? n : d;
		y = (n > d) ? d : n;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		f.num = rar_pkg::RES_NUM_W'(n / x);
		f.den = rar_pkg::RES_DEN_W'(d / x);
		f.status = STATUS_OK;
		return f;
	endfunction

	initial begin
		fail_count = 0;
		pending_count = 0;
	end

	always @(posedge clk) begin
		fraction_t got, want;
		if (arst_n) begin
			// pop before push so a result never meets the request accepted with it
			if (m_axis_tvalid && m_axis_tready) begin
				got.num = m_axis_tdata[rar_pkg::RES_NUM_W-1:0];
				got.den = m_axis_tdata[rar_pkg::RES_NUM_W+rar_pkg::RES_DEN_W-1:
					rar_pkg::RES_NUM_W];
				got.status = m_axis_tuser[0];
				if (expected_fracs.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10) begin
						$display("%0t: result with no request outstanding: %s %0d %0d %0d",
							$realtime, "num den status", got.num, got.den, got.status);
					end
				end else begin
					want = expected_fracs.pop_front();
					if (got.num !== want.num || got.den !== want.den
							|| got.status !== want.status) begin
						fail_count = fail_count + 1;
						if (fail_count <= 10) begin
							$display("%0t: mismatch: expected num %0d den %0d status %0d,",
								$realtime, want.num, want.den, want.status);
							$display("    got num %0d den %0d status %0d",
								got.num, got.den, got.status);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_fracs.push_back(reduced_fraction(s_axis_tuser, s_axis_tdata));
			end
			pending_count <= expected_fracs.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives fraction requests into the rational alu: a directed set of edge
// cases, then random requests over four idle and stall phases. the checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb;

	localparam int OPW = rar_pkg::OPERAND_WIDTH_DEF;
	localparam int IN_W = ((4 * OPW + 7) / 8) * 8;
	localparam int RANDOM_PER_PHASE = 300;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [OPW-1:0] OPND_MAX = '1;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [IN_W-1:0]               s_tdata = '0;
	logic [1:0]                    s_tuser = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [rar_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [0:0]                    m_tuser;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int fail_count;
	int pending_count;
	int idle_pcts[4] = '{0, 54, 0, 6};
	int stall_pcts[4] = '{0, 0, 54, 6};

	always #5 clk = ~clk;

	rational_alu_with_reduction #(.OPERAND_WIDTH(OPW)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	fraction_checker #(.OPW(OPW)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always @(posedge clk) begin
		m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles where neither side moves anything
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_fraction_pair(input logic [1:0] op, input logic [OPW-1:0] an,
			input logic [OPW-1:0] ad, input logic [OPW-1:0] bn, input logic [OPW-1:0] bd);
		logic [IN_W-1:0] data;
		data = '0;
		data[4*OPW-1:0] = {bd, bn, ad, an};
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [OPW-1:0] rand_operand();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 3) begin
			return '0;
		end
		// small values give plenty of common factors to reduce
		if (pick < 25) begin
			return OPW'($urandom_range(16, 1));
		end
		if (pick < 50) begin
			return OPW'($urandom_range(255, 1));
		end
		return OPW'($urandom_range(2 ** OPW - 1, 1));
	endfunction

	task automatic send_random_pair();
		logic [1:0] op;
		logic [OPW-1:0] an, ad, bn, bd;
		op = 2'($urandom_range(3));
		an = rand_operand();
		ad = rand_operand();
		bn = rand_operand();
		bd = rand_operand();
		// equal operands make a zero difference
		if (op == rar_pkg::OP_SUB && $urandom_range(9) == 0) begin
			bn = an;
			bd = ad;
		end
		send_fraction_pair(op, an, ad, bn, bd);
	endtask

	// sender stays quiet until every request has its result
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_fraction_pair(rar_pkg::OP_ADD, 1, 1, 1, 1);
		send_fraction_pair(rar_pkg::OP_ADD, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX);
		send_fraction_pair(rar_pkg::OP_ADD, OPND_MAX, 1, OPND_MAX, 1);
		send_fraction_pair(rar_pkg::OP_ADD, 1, OPND_MAX, 1, OPND_MAX - 1'b1);
		send_fraction_pair(rar_pkg::OP_SUB, 3, 4, 1, 4);
		send_fraction_pair(rar_pkg::OP_SUB, 5, 7, 5, 7);
		send_fraction_pair(rar_pkg::OP_SUB, 1, 2, 3, 4);
		send_fraction_pair(rar_pkg::OP_SUB, OPND_MAX, 1, 1, OPND_MAX);
		send_fraction_pair(rar_pkg::OP_MUL, OPND_MAX, 1, OPND_MAX, 1);
		send_fraction_pair(rar_pkg::OP_MUL, 1, OPND_MAX, 1, OPND_MAX);
		send_fraction_pair(rar_pkg::OP_MUL, 12, 18, 3, 2);
		send_fraction_pair(rar_pkg::OP_DIV, 6, 5, 3, 10);
		send_fraction_pair(rar_pkg::OP_DIV, OPND_MAX, 1, 1, OPND_MAX);
		send_fraction_pair(rar_pkg::OP_DIV, 1234, 4321, 1234, 4321);
		send_fraction_pair(rar_pkg::OP_ADD, 0, 5, 3, 7);
		send_fraction_pair(rar_pkg::OP_SUB, 9, 0, 3, 7);
		send_fraction_pair(rar_pkg::OP_MUL, 9, 5, 0, 7);
		send_fraction_pair(rar_pkg::OP_DIV, 9, 5, 3, 0);
		send_fraction_pair(rar_pkg::OP_DIV, 0, 0, 0, 0);
		// large operands with few common factors
		send_fraction_pair(rar_pkg::OP_ADD, 32749, 32719, 32717, 32713);
		send_fraction_pair(rar_pkg::OP_SUB, 32749, 32719, 32717, 32713);
		wait_for_drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_pcts[ph];
			recv_stall_pct = stall_pcts[ph];
			repeat (RANDOM_PER_PHASE) send_random_pair();
			wait_for_drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
src/rar_pkg.sv
src/rar_ctrl.sv
src/rar_datapath.sv
src/rational_alu_with_reduction.sv
tb/fraction_checker.sv
tb/tb.sv
